FILE: sv/assert_macros.svh
// Assertion macros shared by the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock, quiet during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rv64d_pkg.sv
// Types and constants for the RV64IM instruction decoder
package rv64d_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ERR    = 2'd1;
  localparam logic [1:0] ST_UNIMPL = 2'd2;

  localparam logic [4:0] OPC_LOAD    = 5'h00;
  localparam logic [4:0] OPC_FENCE   = 5'h03;
  localparam logic [4:0] OPC_OPIMM   = 5'h04;
  localparam logic [4:0] OPC_AUIPC   = 5'h05;
  localparam logic [4:0] OPC_OPIMM32 = 5'h06;
  localparam logic [4:0] OPC_STORE   = 5'h08;
  localparam logic [4:0] OPC_OP      = 5'h0C;
  localparam logic [4:0] OPC_LUI     = 5'h0D;
  localparam logic [4:0] OPC_OP32    = 5'h0E;
  localparam logic [4:0] OPC_BRANCH  = 5'h18;
  localparam logic [4:0] OPC_JALR    = 5'h19;
  localparam logic [4:0] OPC_JAL     = 5'h1B;
  localparam logic [4:0] OPC_SYSTEM  = 5'h1C;

  localparam logic [31:0] W_ECALL  = 32'h0000_0073;
  localparam logic [31:0] W_EBREAK = 32'h0010_0073;
  localparam logic [31:0] W_URET   = 32'h0020_0073;
  localparam logic [31:0] W_SRET   = 32'h1020_0073;
  localparam logic [31:0] W_HRET   = 32'h2020_0073;
  localparam logic [31:0] W_MRET   = 32'h3020_0073;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_MUL  = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] F6_SRA  = 6'h10;

  localparam int unsigned QDEPTH = 2;

  // mnemonic codes in dense order
  typedef enum logic [6:0] {
    M_LB, M_LH, M_LW, M_LD, M_LBU, M_LHU, M_LWU, M_FENCE, M_FENCE_I,
    M_MV, M_LI, M_ADDI, M_SLLI, M_SLTI, M_SLTIU, M_XORI, M_SRLI, M_SRAI, M_ORI, M_ANDI,
    M_AUIPC, M_ADDIW, M_SLLIW, M_SRLIW, M_SRAIW, M_SB, M_SH, M_SW, M_SD,
    M_ADD, M_MUL, M_SUB, M_SLL, M_SLT, M_SLTU, M_XOR, M_DIV, M_SRL, M_DIVU, M_SRA,
    M_OR, M_REM, M_AND, M_REMU, M_LUI,
    M_ADDW, M_MULW, M_SUBW, M_SLLW, M_DIVW, M_SRLW, M_DIVUW, M_SRAW, M_REMW, M_REMUW,
    M_BEQZ, M_BEQ, M_BNEZ, M_BNE, M_BLTZ, M_BLT, M_BGEZ, M_BGE, M_BLTUZ, M_BLTU,
    M_BGEUZ, M_BGEU,
    M_RET, M_JR, M_JALR, M_JAL, M_J, M_ECALL, M_EBREAK, M_URET, M_SRET, M_HRET, M_MRET,
    M_CSRW, M_CSRRW, M_CSRR, M_CSRS, M_CSRRS, M_CSRC, M_CSRRC, M_CSRWI, M_CSRRWI,
    M_CSRSI, M_CSRRSI, M_CSRCI, M_CSRRCI
  } mnem_t;

  // Front classification result handed to the back end
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  mnemonic;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [11:0] csr;
    logic        has_target;
    logic [63:0] pc;
  } dec_t;

endpackage

FILE: sv/rv64d_front.sv
// Front end: classify the instruction word into a mnemonic and fields
module rv64d_front import rv64d_pkg::*; (
  input  logic [31:0] word,
  input  logic [63:0] pc,
  output dec_t        dec
);

  logic [4:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd, rs1, rs2;
  logic [31:0] iimm, imm;
  logic [11:0] csr;
  logic        tgt, hit;
  logic [6:0]  code;

  assign opc  = word[6:2];
  assign f3   = word[14:12];
  assign f7   = word[31:25];
  assign rd   = word[11:7];
  assign rs1  = word[19:15];
  assign rs2  = word[24:20];
  assign iimm = {{20{word[31]}}, word[31:20]};

  always_comb begin
    imm  = 32'd0;
    csr  = 12'd0;
    tgt  = 1'b0;
    hit  = 1'b1;
    code = 7'd0;
    unique case (opc)
      OPC_LOAD: begin
        imm = iimm;
        hit = (f3 != 3'd7);
        code = M_LB + {4'd0, f3};
      end
      OPC_FENCE: begin
        imm = iimm;
        hit = (f3 < 3'd2);
        code = M_FENCE + {4'd0, f3};
      end
      OPC_OPIMM: begin
        imm = iimm;
        unique case (f3)
          3'd0: code = (iimm == 32'd0) ? M_MV : ((rs1 == 5'd0) ? M_LI : M_ADDI);
          3'd1: begin code = M_SLLI; imm = {26'd0, word[25:20]}; end
          3'd2: code = M_SLTI;
          3'd3: code = M_SLTIU;
          3'd4: code = M_XORI;
          3'd5: begin
            imm = {26'd0, word[25:20]};
            if (word[31:26] == 6'd0) code = M_SRLI;
            else if (word[31:26] == F6_SRA) code = M_SRAI;
            else hit = 1'b0;
          end
          3'd6: code = M_ORI;
          default: code = M_ANDI;
        endcase
      end
      OPC_AUIPC: begin imm = {word[31:12], 12'd0}; code = M_AUIPC; end
      OPC_OPIMM32: begin
        imm = iimm;
        if (f3 == 3'd0) code = M_ADDIW;
        else if (f3 == 3'd1) begin code = M_SLLIW; imm = {27'd0, rs2}; end
        else if (f3 == 3'd5) begin
          imm = {27'd0, rs2};
          if (f7 == F7_ZERO) code = M_SRLIW;
          else if (f7 == F7_ALT) code = M_SRAIW;
          else hit = 1'b0;
        end else hit = 1'b0;
      end
      OPC_STORE: begin
        imm = {{20{word[31]}}, word[31:25], rd};
        hit = (f3 < 3'd4);
        code = M_SB + {4'd0, f3};
      end
      OPC_OP: begin
        unique case (f3)
          3'd0: if (f7 == F7_ZERO) code = M_ADD; else if (f7 == F7_MUL) code = M_MUL;
                else if (f7 == F7_ALT) code = M_SUB; else hit = 1'b0;
          3'd1: code = M_SLL;
          3'd2: code = M_SLT;
          3'd3: code = M_SLTU;
          3'd4: if (f7 == F7_ZERO) code = M_XOR; else if (f7 == F7_MUL) code = M_DIV;
                else hit = 1'b0;
          3'd5: if (f7 == F7_ZERO) code = M_SRL; else if (f7 == F7_MUL) code = M_DIVU;
                else if (f7 == F7_ALT) code = M_SRA; else hit = 1'b0;
          3'd6: if (f7 == F7_ZERO) code = M_OR; else if (f7 == F7_MUL) code = M_REM;
                else hit = 1'b0;
          default: if (f7 == F7_ZERO) code = M_AND; else if (f7 == F7_MUL) code = M_REMU;
                   else hit = 1'b0;
        endcase
      end
      OPC_LUI: begin imm = {word[31:12], 12'd0}; code = M_LUI; end
      OPC_OP32: begin
        unique case (f3)
          3'd0: if (f7 == F7_ZERO) code = M_ADDW; else if (f7 == F7_MUL) code = M_MULW;
                else if (f7 == F7_ALT) code = M_SUBW; else hit = 1'b0;
          3'd1: code = M_SLLW;
          3'd4: begin code = M_DIVW; hit = (f7 == F7_MUL); end
          3'd5: if (f7 == F7_ZERO) code = M_SRLW; else if (f7 == F7_MUL) code = M_DIVUW;
                else if (f7 == F7_ALT) code = M_SRAW; else hit = 1'b0;
          3'd6: begin code = M_REMW; hit = (f7 == F7_MUL); end
          3'd7: begin code = M_REMUW; hit = (f7 == F7_MUL); end
          default: hit = 1'b0;
        endcase
      end
      OPC_BRANCH: begin
        imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
        tgt = 1'b1;
        if (f3 < 3'd2) code = M_BEQZ + {3'd0, f3, 1'b0} + {6'd0, rs2 != 5'd0};
        else if (f3 >= 3'd4)
          code = M_BLTZ + {3'd0, f3 - 3'd4, 1'b0} + {6'd0, rs2 != 5'd0};
        else hit = 1'b0;
      end
      OPC_JALR: begin
        imm = iimm;
        tgt = 1'b1;
        if (iimm != 32'd0) code = M_JALR;
        else if (rs1 == 5'd1) code = M_RET;
        else code = (rd == 5'd0) ? M_JR : M_JALR;
      end
      OPC_JAL: begin
        imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
        tgt = 1'b1;
        code = (rd == 5'd0) ? M_J : M_JAL;
      end
      OPC_SYSTEM: begin
        imm = iimm;
        csr = word[31:20];
        unique case (f3)
          3'd0: begin
            if (word == W_ECALL) code = M_ECALL;
            else if (word == W_EBREAK) code = M_EBREAK;
            else if (word == W_URET) code = M_URET;
            else if (word == W_SRET) code = M_SRET;
            else if (word == W_HRET) code = M_HRET;
            else if (word == W_MRET) code = M_MRET;
            else hit = 1'b0;
          end
          3'd1: code = (rd == 5'd0) ? M_CSRW : M_CSRRW;
          3'd2: code = (rs1 == 5'd0) ? M_CSRR : ((rd == 5'd0) ? M_CSRS : M_CSRRS);
          3'd3: code = (rd == 5'd0) ? M_CSRC : M_CSRRC;
          3'd5: code = (rd == 5'd0) ? M_CSRWI : M_CSRRWI;
          3'd6: code = (rd == 5'd0) ? M_CSRSI : M_CSRRSI;
          3'd7: code = (rd == 5'd0) ? M_CSRCI : M_CSRRCI;
          default: hit = 1'b0;
        endcase
      end
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    dec = '0;
    if (word[1:0] != 2'b11) begin
      dec.status = ST_ERR;
    end else if (!hit) begin
      dec.status = ST_UNIMPL;
    end else begin
      dec.status     = ST_OK;
      dec.mnemonic   = code;
      dec.rd         = rd;
      dec.rs1        = rs1;
      dec.rs2        = rs2;
      dec.imm        = imm;
      dec.csr        = csr;
      dec.has_target = tgt;
      dec.pc         = pc;
    end
  end

endmodule

FILE: sv/rv64d_queue.sv
// Two-entry queue between decode front and target back end
module rv64d_queue import rv64d_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  dec_t push_data,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output dec_t pop_data
);

  dec_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'(QDEPTH));
  assign nonempty = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/rv64d_back.sv
// Back end: target address add and output register
module rv64d_back import rv64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  dec_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_mnemonic,
  output logic [4:0]  out_dest_reg,
  output logic [4:0]  out_src1_reg,
  output logic [4:0]  out_src2_reg,
  output logic [31:0] out_immediate,
  output logic [11:0] out_csr_number,
  output logic [63:0] out_target_address
);

  logic        valid_r;
  dec_t        d_r;
  logic [63:0] tgt_r, tgt_nxt;

  // Load output register when empty or being drained
  assign q_pop = q_nonempty && (!valid_r || !out_stall);
  assign tgt_nxt = q_data.has_target ? q_data.pc + {{32{q_data.imm[31]}}, q_data.imm} : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (q_pop) valid_r <= 1'b1;
    else if (!out_stall) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      d_r   <= q_data;
      tgt_r <= tgt_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = d_r.status;
  assign out_mnemonic       = d_r.mnemonic;
  assign out_dest_reg       = d_r.rd;
  assign out_src1_reg       = d_r.rs1;
  assign out_src2_reg       = d_r.rs2;
  assign out_immediate      = d_r.imm;
  assign out_csr_number     = d_r.csr;
  assign out_target_address = tgt_r;

endmodule

FILE: sv/rv64_instruction_decoder.sv
// Top level of the RV64IM instruction decoder
//  channel | ports                      | direction
//  in      | in_valid/in_stall + fields | word and address in
//  out     | out_valid/out_stall + flds | decoded result out
// One item per cycle sustained while out_stall is low.
// Each word passes the two-entry queue, then the registered target adder.
// Synchronous active-low reset empties queue and output register.
// in_stall is raised while the queue is full, which follows a stalled output.
`include "assert_macros.svh"
module rv64_instruction_decoder import rv64d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction_word,
  input  logic [63:0] in_instruction_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_mnemonic,
  output logic [4:0]  out_dest_reg,
  output logic [4:0]  out_src1_reg,
  output logic [4:0]  out_src2_reg,
  output logic [31:0] out_immediate,
  output logic [11:0] out_csr_number,
  output logic [63:0] out_target_address
);

  dec_t fdec, qdata;
  logic q_full, q_ne, q_pop, push;

  rv64d_front u_front (
    .word(in_instruction_word), .pc(in_instruction_address), .dec(fdec)
  );

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  rv64d_queue u_queue (
    .clk, .rst_n, .push, .push_data(fdec), .full(q_full),
    .pop(q_pop), .nonempty(q_ne), .pop_data(qdata)
  );

  rv64d_back u_back (
    .clk, .rst_n, .q_nonempty(q_ne), .q_data(qdata), .q_pop,
    .out_valid, .out_stall, .out_status, .out_mnemonic, .out_dest_reg,
    .out_src1_reg, .out_src2_reg, .out_immediate, .out_csr_number,
    .out_target_address
  );

  `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, q_ne, "pop from empty queue")
  `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK,
               out_mnemonic == 7'd0 && out_target_address == 64'd0, "error result not cleared")
  `ASSERT_NEXT(a_push_fill, clk, rst_n, push && !q_pop, q_ne, "queue lost a push")

endmodule
